>>> src/sgsl_pkg.sv
// Shared types and constants for the subjoined glyph stack layout block.
package sgsl_pkg;

  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int CP_W    = 21;
  localparam int ADV_W   = 16;
  localparam int PT_W    = 16;
  localparam int OFS_W   = 40;
  localparam int SCALE_W = 24;

  localparam logic [CP_W-1:0] SUBJ_FIRST_RST = 21'h11CB0;
  localparam logic [CP_W-1:0] SUBJ_LAST_RST  = 21'h11CB6;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_EMPTY  = 2'd1,
    OP_NOGEOM = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    REG_SUBJ_FIRST = 1'b0,
    REG_SUBJ_LAST  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_HALF,
    ST_DONE,
    ST_EMIT
  } state_t;

endpackage

>>> src/sgsl_ifs.sv
// Channel interfaces: glyph requests in, layout results out, register writes.
interface sgsl_glyph_if;
  import sgsl_pkg::*;
  logic                    valid;
  logic                    ready;
  op_t                     op;
  logic                    cluster_start;
  logic [CP_W-1:0]         codepoint;
  logic [ADV_W-1:0]        advance;
  logic signed [PT_W-1:0]  point_x;
  logic signed [PT_W-1:0]  point_y;
  logic                    last_point;

  modport source (output valid, op, cluster_start, codepoint, advance, point_x, point_y,
                  last_point, input ready);
  modport sink (input valid, op, cluster_start, codepoint, advance, point_x, point_y,
                last_point, output ready);
endinterface

interface sgsl_layout_if;
  import sgsl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [OFS_W-1:0]  offset_x;
  logic signed [OFS_W-1:0]  offset_y;
  logic [SCALE_W-1:0]       glyph_scale;
  logic                     stacked;
  logic [ADV_W-1:0]         cluster_advance;

  modport source (output valid, offset_x, offset_y, glyph_scale, stacked, cluster_advance,
                  input ready);
  modport sink (input valid, offset_x, offset_y, glyph_scale, stacked, cluster_advance,
                output ready);
endinterface

interface sgsl_cfg_if;
  import sgsl_pkg::*;
  logic             valid;
  logic             ready;
  cfg_reg_t         index;
  logic [CP_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/sgsl_div.sv
// Restoring divider, one quotient bit per cycle.
module sgsl_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17,
  parameter int QUO_W = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [QUO_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] num_sh;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};
  assign quot  = quo[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        // final bit lands this cycle
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      den_r  <= denom;
      num_sh <= numer;
      quo    <= '0;
    end else if (cnt != '0) begin
      rem    <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      quo    <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

>>> src/subjoined_glyph_stack_layout.sv
// Top level of the subjoined glyph stack layout block.
//
// Glyph outlines arrive as point requests; the block grows a bounding box per
// glyph and emits one layout result when a glyph ends (last point, empty
// outline, or a glyph lacking geometry). Base glyphs get unit scale and zero
// offset and set the reference centre, width and bottom edge; subjoined glyphs
// (codepoint inside the configured range) are scaled to the previous base
// width, hung below the last placed glyph and centred under the base.
// An inner outline point only widens the box, and the block stays idle. A glyph
// lacking geometry goes straight to the emit state, a base glyph end through
// the calc state first. A subjoined glyph with unit or saturated scale, which
// covers every empty outline, skips the divider; one that needs a real scale
// waits on the bit-serial divider, which yields one quotient bit a cycle. The
// four box edges then pass one by one through a single shared multiplier. The
// block takes no new request while a glyph end is being worked; a finished
// result sits in an output register, so the block returns to idle while that
// result waits.
// Registers may be written at any time the block is idle; the register
// channel is always ready, so no write is ever held off.
module subjoined_glyph_stack_layout #(
  parameter int COORD_BITS = sgsl_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = sgsl_pkg::DEF_FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  sgsl_glyph_if.sink     glyph,
  sgsl_layout_if.source  layout,
  sgsl_cfg_if.sink       cfg
);
  import sgsl_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int FW    = FRAC_BITS;
  localparam int WW    = CW + 1;          // box width
  localparam int SW    = FW + 8;          // internal scale, Q8.FW
  localparam int PW    = CW + SW + 1;     // edge times scale
  localparam int SUMW  = PW + 1;
  localparam int NUM_W = WW + FW;

  localparam logic [SW-1:0] SCALE_ONE = SW'(1) << FW;
  localparam logic [SW-1:0] SCALE_MAX = '1;

  // Configuration
  logic [CP_W-1:0] subj_first;
  logic [CP_W-1:0] subj_last;

  // Sequencer
  state_t state, state_next;
  logic   in_fire;
  logic   out_free;

  // Glyph box and cluster state
  logic signed [CW-1:0]    box_left, box_left_next;
  logic signed [CW-1:0]    box_right, box_right_next;
  logic signed [CW-1:0]    box_bottom, box_bottom_next;
  logic signed [CW-1:0]    box_top, box_top_next;
  logic                    glyph_open, glyph_open_next;
  logic signed [OFS_W-1:0] prev_bottom, prev_bottom_next;
  logic signed [OFS_W-1:0] prev_centre, prev_centre_next;
  logic [WW-1:0]           base_width, base_width_next;
  logic [ADV_W-1:0]        max_advance, max_advance_next;

  // Latched glyph identity and working registers
  logic [CP_W-1:0]         cp, cp_next;
  logic [ADV_W-1:0]        adv, adv_next;
  logic [SW-1:0]           scale, scale_next;
  logic [1:0]              mul_idx, mul_idx_next;
  logic signed [PW-1:0]    p_xl, p_xl_next;
  logic signed [PW-1:0]    p_xr, p_xr_next;
  logic signed [PW-1:0]    p_yb, p_yb_next;
  logic signed [PW-1:0]    p_yt, p_yt_next;
  logic signed [SUMW-1:0]  sum_x, sum_x_next;
  logic signed [SUMW-1:0]  half_x, half_x_next;
  logic signed [OFS_W-1:0] dy, dy_next;

  // Staged result and output register
  logic signed [OFS_W-1:0] res_dx, res_dx_next;
  logic signed [OFS_W-1:0] res_dy, res_dy_next;
  logic [SCALE_W-1:0]      res_scale, res_scale_next;
  logic                    res_stacked, res_stacked_next;
  logic [ADV_W-1:0]        res_adv, res_adv_next;
  logic                    out_valid;
  logic signed [OFS_W-1:0] out_dx;
  logic signed [OFS_W-1:0] out_dy;
  logic [SCALE_W-1:0]      out_scale;
  logic                    out_stacked;
  logic [ADV_W-1:0]        out_adv;

  // Combinational helpers
  logic signed [CW-1:0]  px, py;
  logic                  open_eff;
  logic [ADV_W-1:0]      adv_eff;
  logic                  is_sub;
  logic signed [WW-1:0]  wid_raw;
  logic [WW-1:0]         wid;
  logic signed [WW-1:0]  sum_lr;
  logic                  unit_scale;
  logic                  sat_scale;
  logic signed [CW-1:0]  mul_a;
  logic signed [SW:0]    mul_b;
  logic signed [PW-1:0]  mul_p;
  logic                  div_start;
  logic                  div_done;
  logic [SW-1:0]         div_quot;

  // Register writes are never held off
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      subj_first <= SUBJ_FIRST_RST;
      subj_last  <= SUBJ_LAST_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SUBJ_FIRST: subj_first <= cfg.data;
        REG_SUBJ_LAST:  subj_last  <= cfg.data;
      endcase
    end
  end

  assign glyph.ready = (state == ST_IDLE);
  assign in_fire     = glyph.valid && glyph.ready;
  assign out_free    = !out_valid || layout.ready;

  // Wrap incoming points to the coordinate width
  assign px = CW'(glyph.point_x);
  assign py = CW'(glyph.point_y);

  // A cluster start on this request hides the old state
  assign open_eff = glyph_open && !glyph.cluster_start;
  assign adv_eff  = glyph.cluster_start ? '0 : max_advance;

  assign is_sub  = (cp >= subj_first) && (cp <= subj_last);
  assign wid_raw = box_right - box_left;
  assign wid     = wid_raw[WW-1] ? '0 : wid_raw;
  assign sum_lr  = box_left + box_right;

  assign unit_scale = (wid == '0) || (base_width == '0);
  // Quotient would reach 2^(FW+8): clamp instead of dividing
  assign sat_scale  = {8'd0, base_width} >= {wid, 8'd0};

  // Shared multiplier: one box edge per cycle
  always_comb begin
    case (mul_idx)
      2'd0:    mul_a = box_left;
      2'd1:    mul_a = box_right;
      2'd2:    mul_a = box_bottom;
      default: mul_a = box_top;
    endcase
  end
  assign mul_b = $signed({1'b0, scale});
  assign mul_p = mul_a * mul_b;

  sgsl_div #(
    .NUM_W (NUM_W),
    .DEN_W (WW),
    .QUO_W (SW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer ({base_width, {FW{1'b0}}}),
    .denom (wid),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (glyph.op)
            OP_POINT:  if (glyph.last_point) state_next = ST_CALC;
            OP_EMPTY:  state_next = ST_CALC;
            OP_NOGEOM: state_next = ST_EMIT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        if (!is_sub) begin
          state_next = ST_EMIT;
        end else if (unit_scale || sat_scale) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:  if (div_done) state_next = ST_MUL;
      ST_MUL:  if (mul_idx == 2'd3) state_next = ST_SUM;
      ST_SUM:  state_next = ST_HALF;
      ST_HALF: state_next = ST_DONE;
      ST_DONE: state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    box_left_next    = box_left;
    box_right_next   = box_right;
    box_bottom_next  = box_bottom;
    box_top_next     = box_top;
    glyph_open_next  = glyph_open;
    prev_bottom_next = prev_bottom;
    prev_centre_next = prev_centre;
    base_width_next  = base_width;
    max_advance_next = max_advance;
    cp_next          = cp;
    adv_next         = adv;
    scale_next       = scale;
    mul_idx_next     = mul_idx;
    p_xl_next        = p_xl;
    p_xr_next        = p_xr;
    p_yb_next        = p_yb;
    p_yt_next        = p_yt;
    sum_x_next       = sum_x;
    half_x_next      = half_x;
    dy_next          = dy;
    res_dx_next      = res_dx;
    res_dy_next      = res_dy;
    res_scale_next   = res_scale;
    res_stacked_next = res_stacked;
    res_adv_next     = res_adv;
    div_start        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (glyph.cluster_start) begin
            box_left_next    = '0;
            box_right_next   = '0;
            box_bottom_next  = '0;
            box_top_next     = '0;
            glyph_open_next  = 1'b0;
            prev_bottom_next = '0;
            prev_centre_next = '0;
            base_width_next  = '0;
            max_advance_next = '0;
          end
          cp_next  = glyph.codepoint;
          adv_next = glyph.advance;
          unique case (glyph.op)
            OP_POINT: begin
              if (!open_eff) begin
                // first point opens the box
                box_left_next   = px;
                box_right_next  = px;
                box_bottom_next = py;
                box_top_next    = py;
              end else begin
                if (px < box_left)   box_left_next   = px;
                if (px > box_right)  box_right_next  = px;
                if (py < box_bottom) box_bottom_next = py;
                if (py > box_top)    box_top_next    = py;
              end
              glyph_open_next = !glyph.last_point;
            end
            OP_EMPTY: begin
              box_left_next   = '0;
              box_right_next  = '0;
              box_bottom_next = '0;
              box_top_next    = '0;
              glyph_open_next = 1'b0;
            end
            OP_NOGEOM: begin
              glyph_open_next  = 1'b0;
              res_dx_next      = '0;
              res_dy_next      = '0;
              res_scale_next   = SCALE_W'(SCALE_ONE);
              res_stacked_next = 1'b0;
              res_adv_next     = adv_eff;
            end
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        mul_idx_next = 2'd0;
        if (!is_sub) begin
          // base glyph: becomes the reference for later subjoined glyphs
          prev_centre_next = OFS_W'(sum_lr) <<< (FW - 1);
          prev_bottom_next = OFS_W'(box_bottom) <<< FW;
          base_width_next  = wid;
          if (adv > max_advance) max_advance_next = adv;
          res_dx_next      = '0;
          res_dy_next      = '0;
          res_scale_next   = SCALE_W'(SCALE_ONE);
          res_stacked_next = 1'b0;
          res_adv_next     = (adv > max_advance) ? adv : max_advance;
        end else if (unit_scale) begin
          scale_next = SCALE_ONE;
        end else if (sat_scale) begin
          scale_next = SCALE_MAX;
        end else begin
          div_start = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) scale_next = div_quot;
      end
      ST_MUL: begin
        case (mul_idx)
          2'd0:    p_xl_next = mul_p;
          2'd1:    p_xr_next = mul_p;
          2'd2:    p_yb_next = mul_p;
          default: p_yt_next = mul_p;
        endcase
        mul_idx_next = mul_idx + 2'd1;
      end
      ST_SUM: begin
        sum_x_next = p_xl + p_xr;
        // top edge meets the previous bottom edge
        dy_next    = prev_bottom - OFS_W'(p_yt);
      end
      ST_HALF: begin
        // halve toward zero
        half_x_next = $signed(sum_x + {{(SUMW-1){1'b0}}, sum_x[SUMW-1]}) >>> 1;
      end
      ST_DONE: begin
        res_dx_next      = prev_centre - OFS_W'(half_x);
        res_dy_next      = dy;
        res_scale_next   = SCALE_W'(scale);
        res_stacked_next = 1'b1;
        res_adv_next     = max_advance;
        prev_bottom_next = OFS_W'(p_yb) + dy;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      glyph_open  <= 1'b0;
      box_left    <= '0;
      box_right   <= '0;
      box_bottom  <= '0;
      box_top     <= '0;
      prev_bottom <= '0;
      prev_centre <= '0;
      base_width  <= '0;
      max_advance <= '0;
      mul_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      glyph_open  <= glyph_open_next;
      box_left    <= box_left_next;
      box_right   <= box_right_next;
      box_bottom  <= box_bottom_next;
      box_top     <= box_top_next;
      prev_bottom <= prev_bottom_next;
      prev_centre <= prev_centre_next;
      base_width  <= base_width_next;
      max_advance <= max_advance_next;
      mul_idx     <= mul_idx_next;
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (layout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    cp          <= cp_next;
    adv         <= adv_next;
    scale       <= scale_next;
    p_xl        <= p_xl_next;
    p_xr        <= p_xr_next;
    p_yb        <= p_yb_next;
    p_yt        <= p_yt_next;
    sum_x       <= sum_x_next;
    half_x      <= half_x_next;
    dy          <= dy_next;
    res_dx      <= res_dx_next;
    res_dy      <= res_dy_next;
    res_scale   <= res_scale_next;
    res_stacked <= res_stacked_next;
    res_adv     <= res_adv_next;
    if (state == ST_EMIT && out_free) begin
      out_dx      <= res_dx;
      out_dy      <= res_dy;
      out_scale   <= res_scale;
      out_stacked <= res_stacked;
      out_adv     <= res_adv;
    end
  end

  assign layout.valid           = out_valid;
  assign layout.offset_x        = out_dx;
  assign layout.offset_y        = out_dy;
  assign layout.glyph_scale     = out_scale;
  assign layout.stacked         = out_stacked;
  assign layout.cluster_advance = out_adv;

endmodule

>>> tb/sv/subjoined_glyph_stack_layout_tb.sv
// Self-checking testbench for the subjoined glyph stack layout block.
module subjoined_glyph_stack_layout_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sgsl_pkg::*;

  // Op code 3 has no member in the package enum; the block must ignore it.
  localparam op_t OP_UNUSED = op_t'(2'd3);

  localparam logic [SCALE_W-1:0] UNIT_SCALE = 24'h010000;
  localparam longint ONE_Q = 64'sd65536;
  localparam longint SCALE_CEIL = (64'sd1 << 24) - 1;
  localparam logic [CP_W-1:0] CP_TOP = 21'h10FFFF;

  // An inner point may still be in flight when the last result leaves, so
  // wait well past the slowest glyph end.
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;
  localparam int IDLE_PCT = 19;
  localparam int PHASE_ITEMS = 400;

  typedef struct packed {
    op_t                    op;
    logic                   cluster_start;
    logic [CP_W-1:0]        codepoint;
    logic [ADV_W-1:0]       advance;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   last_point;
  } glyph_req_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] offset_x;
    logic signed [OFS_W-1:0] offset_y;
    logic [SCALE_W-1:0]      glyph_scale;
    logic                    stacked;
    logic [ADV_W-1:0]        cluster_advance;
  } layout_t;

  // One directed request; when typed is set, want holds the result to expect.
  typedef struct packed {
    glyph_req_t req;
    logic       typed;
    layout_t    want;
  } directed_row_t;

  localparam layout_t NO_LAYOUT = '0;

  logic clk;
  logic rst;

  sgsl_glyph_if  glyph_ch ();
  sgsl_layout_if layout_ch ();
  sgsl_cfg_if    cfg_ch ();

  subjoined_glyph_stack_layout i_dut (
    .clk    (clk),
    .rst    (rst),
    .glyph  (glyph_ch),
    .layout (layout_ch),
    .cfg    (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5ns;
    clk = 1'b1;
    #5ns;
  end

  // ---------------------------------------------------------------------
  // Layout predictor: a private copy of the cluster state and the range.
  // ---------------------------------------------------------------------
  logic [CP_W-1:0]         subj_first;
  logic [CP_W-1:0]         subj_last;
  logic signed [PT_W-1:0]  box_l, box_r, box_b, box_t;
  logic                    glyph_open;
  logic signed [OFS_W-1:0] stack_bottom;   // bottom edge of the last placed glyph
  logic signed [OFS_W-1:0] base_centre;    // box centre of the last base glyph
  logic [PT_W:0]           base_width;     // box width of the last base glyph
  logic [ADV_W-1:0]        peak_advance;

  layout_t expected_layouts [$];

  function automatic void clear_cluster_state();
    box_l = '0;
    box_r = '0;
    box_b = '0;
    box_t = '0;
    glyph_open = 1'b0;
    stack_bottom = '0;
    base_centre = '0;
    base_width = '0;
    peak_advance = '0;
  endfunction

  // Advance the predictor by one request; return 1 when it yields a result.
  function automatic logic predict_layout(input glyph_req_t r, output layout_t res);
    longint wid, scl, xl, xr, yb, yt;
    logic signed [OFS_W-1:0] dx, dy;
    logic sub;
    res = '0;
    if (r.cluster_start) clear_cluster_state();
    if (r.op == OP_UNUSED) return 1'b0;
    if (r.op == OP_NOGEOM) begin
      // Drop any open box and leave the layout state alone.
      glyph_open = 1'b0;
      res = '{40'sd0, 40'sd0, UNIT_SCALE, 1'b0, peak_advance};
      return 1'b1;
    end
    if (r.op == OP_POINT) begin
      if (!glyph_open) begin
        box_l = r.point_x;
        box_r = r.point_x;
        box_b = r.point_y;
        box_t = r.point_y;
        glyph_open = 1'b1;
      end else begin
        if (r.point_x < box_l) box_l = r.point_x;
        if (r.point_x > box_r) box_r = r.point_x;
        if (r.point_y < box_b) box_b = r.point_y;
        if (r.point_y > box_t) box_t = r.point_y;
      end
      if (!r.last_point) return 1'b0;
    end else begin
      box_l = '0;
      box_r = '0;
      box_b = '0;
      box_t = '0;
    end

    wid = longint'(box_r) - longint'(box_l);
    if (wid < 0) wid = 0;
    sub = (r.codepoint >= subj_first) && (r.codepoint <= subj_last);
    scl = ONE_Q;
    dx = '0;
    dy = '0;
    if (sub) begin
      if (wid > 0 && base_width != 0) begin
        scl = (longint'(base_width) * ONE_Q) / wid;
        if (scl > SCALE_CEIL) scl = SCALE_CEIL;
      end
      xl = longint'(box_l) * scl;
      xr = longint'(box_r) * scl;
      yb = longint'(box_b) * scl;
      yt = longint'(box_t) * scl;
      // Hang the top edge on the last bottom edge, centre under the base.
      dy = OFS_W'(stack_bottom - yt);
      dx = OFS_W'(base_centre - (xl + xr) / 2);
      stack_bottom = OFS_W'(yb + dy);
    end else begin
      base_centre = OFS_W'((longint'(box_l) + longint'(box_r)) * (ONE_Q / 2));
      base_width = wid[PT_W:0];
      if (r.advance > peak_advance) peak_advance = r.advance;
      stack_bottom = OFS_W'(longint'(box_b) * ONE_Q);
    end
    glyph_open = 1'b0;
    res = '{dx, dy, scl[SCALE_W-1:0], sub, peak_advance};
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table: extremes, every op and the corner cases, run with the
  // range at its reset value. Typed rows carry a result read off by eye.
  // ---------------------------------------------------------------------
  directed_row_t directed_rows [25] = '{
    // missing geometry straight after reset
    '{'{OP_NOGEOM, 1'b0, 21'h41, 16'd0, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{40'sd0, 40'sd0, UNIT_SCALE, 1'b0, 16'd0}},
    // unknown op with every other field high: dropped, only the clear acts
    '{'{OP_UNUSED, 1'b1, CP_TOP, 16'hFFFF, -16'sd1, -16'sd1, 1'b1},
      1'b0, NO_LAYOUT},
    // empty base glyph with the largest advance
    '{'{OP_EMPTY, 1'b1, 21'h41, 16'hFFFF, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{40'sd0, 40'sd0, UNIT_SCALE, 1'b0, 16'hFFFF}},
    // empty subjoined glyph under a zero-width base: unit scale
    '{'{OP_EMPTY, 1'b0, 21'h11CB0, 16'd5, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{40'sd0, 40'sd0, UNIT_SCALE, 1'b1, 16'hFFFF}},
    // full-range base glyph; the first point's identity is ignored
    '{'{OP_POINT, 1'b1, 21'h41, 16'd100, 16'sh8000, 16'sh8000, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h42, 16'd1000, 16'sh7FFF, 16'sh7FFF, 1'b1}, 1'b0, NO_LAYOUT},
    // one-unit subjoined glyph under that base: scale saturates
    '{'{OP_POINT, 1'b0, 21'h11CB6, 16'd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h11CB6, 16'd7, 16'sd1, -16'sd1, 1'b1}, 1'b0, NO_LAYOUT},
    // abandoned glyph: open box dropped by missing geometry
    '{'{OP_POINT, 1'b0, 21'h43, 16'd0, -16'sd5, 16'sd10, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_NOGEOM, 1'b0, 21'h43, 16'd0, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{40'sd0, 40'sd0, UNIT_SCALE, 1'b0, 16'd1000}},
    // single-point subjoined glyph: zero width, unit scale
    '{'{OP_POINT, 1'b0, 21'h11CB3, 16'd3, 16'sd10, 16'sd20, 1'b1}, 1'b0, NO_LAYOUT},
    // cluster start in the middle of a glyph
    '{'{OP_POINT, 1'b0, 21'h44, 16'd0, 16'sd3, 16'sd3, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b1, 21'h44, 16'd200, -16'sd7, 16'sd4, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h44, 16'd300, 16'sd7, -16'sd4, 1'b1}, 1'b0, NO_LAYOUT},
    // subjoined glyph that needs a real scale and an odd centre sum
    '{'{OP_POINT, 1'b0, 21'h11CB1, 16'd0, -16'sd2, 16'sd5, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h11CB1, 16'd0, 16'sd3, -16'sd6, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h11CB1, 16'd0, 16'sd0, 16'sd9, 1'b1}, 1'b0, NO_LAYOUT},
    '{'{OP_EMPTY, 1'b0, 21'h11CB2, 16'd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_UNUSED, 1'b0, 21'h41, 16'd0, 16'sd0, 16'sd0, 1'b1}, 1'b0, NO_LAYOUT},
    // codepoints just outside the range are base glyphs
    '{'{OP_POINT, 1'b0, 21'h11CAF, 16'd50, -16'sd100, -16'sd100, 1'b1}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h11CB7, 16'd60, 16'sd100, -16'sd50, 1'b1}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h11CB0, 16'd0, -16'sd300, 16'sd200, 1'b0}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h11CB0, 16'd0, 16'sd300, -16'sd200, 1'b1}, 1'b0, NO_LAYOUT},
    '{'{OP_POINT, 1'b0, 21'h0, 16'hFFFF, 16'sd5, 16'sd5, 1'b1}, 1'b0, NO_LAYOUT},
    // empty base glyph opening a fresh cluster
    '{'{OP_EMPTY, 1'b1, 21'h0, 16'd0, 16'sd0, 16'sd0, 1'b0},
      1'b1, '{40'sd0, 40'sd0, UNIT_SCALE, 1'b0, 16'd0}}
  };

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  int src_idle_pct;
  int snk_idle_pct;
  int glyph_items;       // accepted requests of the current phase, op 3 left out
  int mismatches;
  bit long_hold_go;

  // Offer one request and hold it until the block takes it; predict on accept.
  task automatic send_req(input glyph_req_t r, input logic typed, input layout_t want);
    layout_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      glyph_ch.valid <= 1'b0;
      @(posedge clk);
    end
    glyph_ch.op            <= r.op;
    glyph_ch.cluster_start <= r.cluster_start;
    glyph_ch.codepoint     <= r.codepoint;
    glyph_ch.advance       <= r.advance;
    glyph_ch.point_x       <= r.point_x;
    glyph_ch.point_y       <= r.point_y;
    glyph_ch.last_point    <= r.last_point;
    glyph_ch.valid         <= 1'b1;
    @(posedge clk);
    while (!glyph_ch.ready) @(posedge clk);
    if (predict_layout(r, res)) expected_layouts.push_back(typed ? want : res);
    if (r.op != OP_UNUSED) glyph_items++;
  endtask

  // Mostly small boxes so scales stay meaningful, with extremes now and then.
  function automatic logic signed [PT_W-1:0] rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return PT_W'(int'($urandom_range(400)) - 200);
    if (pick < 85) return pick[0] ? 16'sh7FFF : 16'sh8000;
    return PT_W'($urandom);
  endfunction

  function automatic logic [CP_W-1:0] pick_cp(input logic want_sub);
    if (want_sub && subj_first <= subj_last)
      return CP_W'($urandom_range(subj_last, subj_first));
    return CP_W'($urandom_range(CP_TOP));
  endfunction

  function automatic glyph_req_t random_req();
    glyph_req_t r;
    r.op = op_t'(2'($urandom_range(3)));
    r.cluster_start = ($urandom_range(7) == 0);
    r.codepoint = CP_W'($urandom_range(CP_TOP));
    r.advance = ADV_W'($urandom);
    r.point_x = PT_W'($urandom);
    r.point_y = PT_W'($urandom);
    r.last_point = 1'($urandom_range(1));
    return r;
  endfunction

  // One glyph: usually a point stream, sometimes empty or lacking geometry.
  task automatic send_glyph(input logic cs, input logic [CP_W-1:0] cp);
    glyph_req_t r;
    int npts;
    int kind;
    int k;
    kind = $urandom_range(99);
    r = random_req();
    if (kind < 8) begin
      r.op = OP_EMPTY;
      r.cluster_start = cs;
      r.codepoint = cp;
      send_req(r, 1'b0, NO_LAYOUT);
    end else if (kind < 12) begin
      r.op = OP_NOGEOM;
      r.cluster_start = cs;
      send_req(r, 1'b0, NO_LAYOUT);
    end else begin
      npts = $urandom_range(8, 1);
      for (k = 0; k < npts; k++) begin
        r = random_req();
        r.op = OP_POINT;
        r.cluster_start = cs && (k == 0);
        if (k == npts - 1) r.codepoint = cp;
        r.point_x = rand_coord();
        r.point_y = rand_coord();
        r.last_point = (k == npts - 1);
        send_req(r, 1'b0, NO_LAYOUT);
      end
    end
  endtask

  // A well-formed cluster: a base glyph, up to three glyphs stacked under it, and now and then a trailing base glyph.
  task automatic send_cluster();
    int subs;
    send_glyph(1'b1, pick_cp(1'b0));
    subs = $urandom_range(3);
    repeat (subs) send_glyph(1'b0, pick_cp(1'b1));
    if ($urandom_range(5) == 0) send_glyph(1'b0, pick_cp(1'b0));
  endtask

  task automatic write_subjoined_range(input logic [CP_W-1:0] lo, input logic [CP_W-1:0] hi);
    cfg_ch.index <= REG_SUBJ_FIRST;
    cfg_ch.data  <= lo;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    subj_first = lo;
    cfg_ch.index <= REG_SUBJ_LAST;
    cfg_ch.data  <= hi;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    subj_last = hi;
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, drain every expected result, then let a last point finish.
  task automatic settle();
    glyph_ch.valid <= 1'b0;
    while (expected_layouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int burst;
    logic [CP_W-1:0] lo, hi;
    rst = 1'b1;
    glyph_ch.valid = 1'b0;
    glyph_ch.op = OP_POINT;
    glyph_ch.cluster_start = 1'b0;
    glyph_ch.codepoint = '0;
    glyph_ch.advance = '0;
    glyph_ch.point_x = '0;
    glyph_ch.point_y = '0;
    glyph_ch.last_point = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SUBJ_FIRST;
    cfg_ch.data = '0;
    layout_ch.ready = 1'b0;
    src_idle_pct = IDLE_PCT;
    snk_idle_pct = IDLE_PCT;
    mismatches = 0;
    long_hold_go = 1'b0;
    subj_first = SUBJ_FIRST_RST;
    subj_last = SUBJ_LAST_RST;
    clear_cluster_state();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    settle();

    // Phases: reset range, everything subjoined, empty range, only codepoint
    // zero, then a narrow random window.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          lo = SUBJ_FIRST_RST;
          hi = SUBJ_LAST_RST;
        end
        1: begin
          lo = '0;
          hi = CP_TOP;
        end
        2: begin
          lo = CP_TOP;
          hi = '0;
        end
        3: begin
          lo = '0;
          hi = '0;
        end
        default: begin
          lo = CP_W'($urandom_range(CP_TOP - 64));
          hi = lo + CP_W'($urandom_range(63));
        end
      endcase
      write_subjoined_range(lo, hi);
      glyph_items = 0;
      while (glyph_items < PHASE_ITEMS) begin
        // Hold both sides busy without gaps for a long stretch of the last phase.
        src_idle_pct = (phase == 4 && glyph_items < 200) ? 0 : IDLE_PCT;
        snk_idle_pct = src_idle_pct;
        // Stall the result side for a long while so the block backs up.
        if (phase == 0 && glyph_items >= 150) long_hold_go = 1'b1;
        if ($urandom_range(99) < 80) begin
          send_cluster();
        end else begin
          // Noise: random ops, broken glyphs, stray cluster starts.
          burst = $urandom_range(4, 1);
          repeat (burst) send_req(random_req(), 1'b0, NO_LAYOUT);
        end
      end
      settle();
    end

    if (mismatches == 0 && expected_layouts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random stalls, one long hold-off, in-order checking.
  // ---------------------------------------------------------------------
  bit long_hold_done;
  int hold_left;

  task automatic compare_field(input string name, input logic signed [OFS_W-1:0] want,
                               input logic signed [OFS_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  task automatic check_layout();
    layout_t want;
    if (expected_layouts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: layout result with none expected, offset_x %0d offset_y %0d",
                 $realtime, layout_ch.offset_x, layout_ch.offset_y);
    end else begin
      want = expected_layouts.pop_front();
      compare_field("offset_x", want.offset_x, layout_ch.offset_x);
      compare_field("offset_y", want.offset_y, layout_ch.offset_y);
      compare_field("glyph_scale", OFS_W'(want.glyph_scale),
                    OFS_W'(layout_ch.glyph_scale));
      compare_field("stacked", OFS_W'(want.stacked), OFS_W'(layout_ch.stacked));
      compare_field("cluster_advance", OFS_W'(want.cluster_advance),
                    OFS_W'(layout_ch.cluster_advance));
    end
  endtask

  initial begin
    long_hold_done = 1'b0;
    hold_left = 0;
  end

  always @(posedge clk) begin
    if (!rst && layout_ch.valid === 1'b1 && layout_ch.ready === 1'b1) check_layout();
    if (long_hold_go && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      layout_ch.ready <= 1'b0;
    end else begin
      layout_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: end the run if the block hangs.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

>>> filelist.f
src/sgsl_pkg.sv
src/sgsl_ifs.sv
src/sgsl_div.sv
src/subjoined_glyph_stack_layout.sv
tb/sv/subjoined_glyph_stack_layout_tb.sv
